// ===== rtl/nte_pkg.sv =====
// nte_pkg: shared types and constants for the neighbor table engine
// no dependencies; used by nte_ctrl, nte_dp and neighbor_table_engine_core in rtl
package nte_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [16:0] TRUST_ONE = 17'd65536;
  localparam logic [8:0] WEIGHT_ONE = 9'd256;
  localparam logic [4:0] MISS_LIMIT = 5'd20;
  // floor(n / 10) == (n * DIV10_MUL) >> DIV10_SHIFT for n < 2^22
  localparam logic [19:0] DIV10_MUL = 20'd838861;
  localparam int DIV10_SHIFT = 23;

  typedef enum logic [1:0] {
    OP_BEACON = 2'd0,
    OP_TRUST  = 2'd1,
    OP_CLEAN  = 2'd2,
    OP_HEAD   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CLEANED   = 3'd4,
    ST_HEAD      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_WEIGHT   = 2'd0,
    REG_NB_TMO   = 2'd1,
    REG_HEAD_TMO = 2'd2,
    REG_THRESH   = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_CHECK,
    FSM_CALC,
    FSM_WRITE,
    FSM_APPEND,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [31:0]        node_id;
    logic [47:0]        mac;
    logic [7:0]         last_seq;
    logic signed [15:0] rssi_avg;
    logic [31:0]        last_seen;
    logic               is_head;
    logic [31:0]        head_time;
    logic [16:0]        trust;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic start;
    logic chk;
    logic calc;
    logic upd;
    logic app;
    logic scan_end;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    op_e  op;
    logic hit;
    logic head_hit;
    logic room;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/nte_ram.sv =====
// nte_ram: generic single write port ram with registered read
// no dependencies
module nte_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/nte_ctrl.sv =====
// nte_ctrl: sequencing state machine for the neighbor table engine
// depends on nte_pkg
module nte_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  nte_pkg::sts_t sts_i,
  output nte_pkg::cmd_t cmd_o
);
  import nte_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) state_d = FSM_READ;
      end
      FSM_READ: begin
        if (!sts_i.at_end) begin
          state_d = FSM_CHECK;
        end else if (sts_i.op == OP_BEACON && sts_i.room) begin
          state_d = FSM_APPEND;
        end else begin
          state_d = FSM_DONE;
        end
      end
      FSM_CHECK: begin
        if ((sts_i.op == OP_BEACON || sts_i.op == OP_TRUST) && sts_i.hit) begin
          state_d = FSM_CALC;
        end else if (sts_i.op == OP_HEAD && sts_i.head_hit) begin
          state_d = FSM_DONE;
        end else begin
          state_d = FSM_READ;
        end
      end
      FSM_CALC:   state_d = FSM_WRITE;
      FSM_WRITE:  state_d = FSM_DONE;
      FSM_APPEND: state_d = FSM_DONE;
      FSM_DONE: begin
        if (sts_i.out_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      FSM_READ: begin
        cmd_o.scan_end = sts_i.at_end;
      end
      FSM_CHECK:  cmd_o.chk = 1'b1;
      FSM_CALC:   cmd_o.calc = 1'b1;
      FSM_WRITE:  cmd_o.upd = 1'b1;
      FSM_APPEND: cmd_o.app = 1'b1;
      FSM_DONE:   cmd_o.emit = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/nte_dp.sv =====
// nte_dp: item registers, config registers, table ram, arithmetic and result register
// depends on nte_pkg and nte_ram
module nte_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nte_pkg::cmd_t        cmd_i,
  output nte_pkg::sts_t        sts_o,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [1:0]           op_i,
  input  logic [31:0]          now_ms_i,
  input  logic [31:0]          node_id_i,
  input  logic [47:0]          mac_addr_i,
  input  logic                 mac_valid_i,
  input  logic signed [7:0]    rssi_i,
  input  logic [16:0]          trust_in_i,
  input  logic                 is_head_i,
  input  logic [7:0]           seq_num_i,
  input  logic                 success_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [4:0]           missed_count_o,
  output logic [4:0]           entry_count_o,
  output logic signed [15:0]   rssi_avg_out_o,
  output logic                 in_cluster_o,
  output logic [16:0]          trust_out_o,
  output logic                 head_found_o,
  output logic [31:0]          head_node_id_o,
  output logic [47:0]          head_mac_o
);
  import nte_pkg::*;

  // configuration
  logic [8:0]        weight_q;
  logic [31:0]       nb_tmo_q, head_tmo_q;
  logic signed [7:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q   <= 9'd77;
      nb_tmo_q   <= 32'd30000;
      head_tmo_q <= 32'd10000;
      thresh_q   <= -8'sd70;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_WEIGHT:   weight_q <= cfg_data_i[8:0];
        REG_NB_TMO:   nb_tmo_q <= cfg_data_i;
        REG_HEAD_TMO: head_tmo_q <= cfg_data_i;
        REG_THRESH:   thresh_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // latched item
  op_e               op_q;
  logic [31:0]       now_q, id_q;
  logic [47:0]       mac_q;
  logic              macv_q, head_q, succ_q;
  logic signed [7:0] rssi_q;
  logic [16:0]       trust_q;
  logic [7:0]        seq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q    <= op_e'(op_i);
      now_q   <= now_ms_i;
      id_q    <= node_id_i;
      mac_q   <= mac_addr_i;
      macv_q  <= mac_valid_i;
      rssi_q  <= rssi_i;
      trust_q <= (trust_in_i > TRUST_ONE) ? TRUST_ONE : trust_in_i;
      head_q  <= is_head_i;
      seq_q   <= seq_num_i;
      succ_q  <= success_i;
    end
  end

  // scan counters and entry count
  logic [CNT_W-1:0] idx_q, wr_q, cnt_q;

  // table
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata, rdata, ent_q, upd;
  logic [ENTRY_W-1:0] rdata_raw;

  nte_ram #(.Width(ENTRY_W), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  logic hit, keep, head_hit;
  logic [31:0] age_seen, age_head;
  assign age_seen = now_q - rdata.last_seen;
  assign age_head = now_q - rdata.head_time;
  assign hit      = rdata.node_id == id_q;
  assign keep     = age_seen < nb_tmo_q;
  assign head_hit = rdata.is_head && (age_head < head_tmo_q);

  // arithmetic
  logic [8:0]          w_eff, w_inv;
  logic signed [15:0]  rssi256;
  logic signed [25:0]  prod_a_q, prod_b_q, blend_sum;
  logic [19:0]         tnum;
  logic [39:0]         tprod_q;
  logic signed [15:0]  blend_avg, new_avg;
  logic [7:0]          gap;
  logic [4:0]          missed;
  logic [16:0]         ev_trust;

  assign w_eff   = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
  assign w_inv   = WEIGHT_ONE - w_eff;
  assign rssi256 = {rssi_q, 8'd0};
  assign tnum    = ({3'd0, ent_q.trust} << 3) + {3'd0, ent_q.trust}
                   + (succ_q ? {3'd0, TRUST_ONE} : 20'd0) + 20'd5;

  always_ff @(posedge clk_i) begin
    if (cmd_i.chk) ent_q <= rdata;
    if (cmd_i.calc) begin
      prod_a_q <= $signed({1'b0, w_eff}) * rssi256;
      prod_b_q <= $signed({1'b0, w_inv}) * ent_q.rssi_avg;
      tprod_q  <= tnum * DIV10_MUL;
    end
  end

  assign blend_sum = prod_a_q + prod_b_q + 26'sd128;
  assign blend_avg = blend_sum[23:8];
  assign new_avg   = (ent_q.rssi_avg == 16'sd0) ? rssi256 : blend_avg;
  assign ev_trust  = tprod_q[DIV10_SHIFT +: 17];
  assign gap       = seq_q - ent_q.last_seq;
  always_comb begin
    missed = 5'd0;
    if (gap > 8'd1 && (gap - 8'd1) <= {3'd0, MISS_LIMIT}) missed = 5'(gap - 8'd1);
  end

  always_comb begin
    upd = ent_q;
    if (op_q == OP_BEACON) begin
      upd.last_seq  = seq_q;
      if (macv_q) upd.mac = mac_q;
      upd.rssi_avg  = new_avg;
      upd.trust     = trust_q;
      upd.last_seen = now_q;
      upd.is_head   = head_q;
      if (head_q) upd.head_time = now_q;
    end else begin
      upd.trust = ev_trust;
    end
  end

  entry_t fresh;
  always_comb begin
    fresh.node_id   = id_q;
    fresh.mac       = macv_q ? mac_q : 48'd0;
    fresh.last_seq  = seq_q;
    fresh.rssi_avg  = rssi256;
    fresh.last_seen = now_q;
    fresh.is_head   = head_q;
    fresh.head_time = head_q ? now_q : 32'd0;
    fresh.trust     = trust_q;
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = idx_q[IDX_W-1:0];
    wdata = upd;
    if (cmd_i.chk && op_q == OP_CLEAN && keep) begin
      we    = 1'b1;
      waddr = wr_q[IDX_W-1:0];
      wdata = rdata;
    end else if (cmd_i.upd) begin
      we = 1'b1;
    end else if (cmd_i.app) begin
      we    = 1'b1;
      waddr = cnt_q[IDX_W-1:0];
      wdata = fresh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.start) begin
        idx_q <= '0;
        wr_q  <= '0;
      end
      if (cmd_i.chk) begin
        if (op_q == OP_CLEAN && keep) wr_q <= wr_q + 1'b1;
        if (!(hit && (op_q == OP_BEACON || op_q == OP_TRUST))) idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.scan_end && op_q == OP_CLEAN) cnt_q <= wr_q;
      if (cmd_i.app) cnt_q <= cnt_q + 1'b1;
    end
  end

  // result being built
  logic [2:0]         r_status;
  logic [4:0]         r_missed;
  logic signed [15:0] r_avg;
  logic [16:0]        r_trust;
  logic               r_found;
  logic [31:0]        r_hid;
  logic [47:0]        r_hmac;
  logic signed [15:0] thr256;
  assign thr256 = {thresh_q, 8'd0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      r_missed <= '0;
      r_avg    <= '0;
      r_trust  <= '0;
      r_found  <= 1'b0;
      r_hid    <= '0;
      r_hmac   <= '0;
    end
    if (cmd_i.scan_end) begin
      case (op_q)
        OP_BEACON: r_status <= ST_FULL;
        OP_TRUST:  r_status <= ST_NOT_FOUND;
        OP_CLEAN:  r_status <= ST_CLEANED;
        default:   r_status <= ST_HEAD;
      endcase
    end
    if (cmd_i.chk && op_q == OP_HEAD && head_hit) begin
      r_status <= ST_HEAD;
      r_found  <= 1'b1;
      r_hid    <= rdata.node_id;
      r_hmac   <= rdata.mac;
    end
    if (cmd_i.upd) begin
      r_status <= ST_UPDATED;
      r_missed <= (op_q == OP_BEACON) ? missed : 5'd0;
      r_avg    <= upd.rssi_avg;
      r_trust  <= upd.trust;
    end
    if (cmd_i.app) begin
      r_status <= ST_ADDED;
      r_avg    <= fresh.rssi_avg;
      r_trust  <= fresh.trust;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o       <= r_status;
      missed_count_o <= r_missed;
      entry_count_o  <= 5'(cnt_q);
      rssi_avg_out_o <= r_avg;
      in_cluster_o   <= (r_status == ST_UPDATED || r_status == ST_ADDED)
                        && (r_avg >= thr256);
      trust_out_o    <= r_trust;
      head_found_o   <= r_found;
      head_node_id_o <= r_hid;
      head_mac_o     <= r_hmac;
    end
  end

  always_comb begin
    sts_o.at_end   = idx_q >= cnt_q;
    sts_o.op       = op_q;
    sts_o.hit      = hit;
    sts_o.head_hit = head_hit;
    sts_o.room     = cnt_q < CNT_W'(TABLE_DEPTH);
    sts_o.out_free = !out_valid_o || out_ready_i;
  end

endmodule

// ===== rtl/neighbor_table_engine_core.sv =====
// neighbor_table_engine_core: top level, controller plus datapath
// depends on nte_pkg, nte_ctrl, nte_dp (and nte_ram below it)
// one item at a time: in_ready_o is high only while the controller is idle, so a new item
// is taken only after the previous one has finished its scan and reached the output
// register; the table ram scan goes through its single read port
// a finished result waits in the output register while the next item is taken
// reset: async active low, clears the entry count and the controller, loads config defaults
module neighbor_table_engine_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [31:0]         now_ms_i,
  input  logic [31:0]         node_id_i,
  input  logic [47:0]         mac_addr_i,
  input  logic                mac_valid_i,
  input  logic signed [7:0]   rssi_i,
  input  logic [16:0]         trust_in_i,
  input  logic                is_head_i,
  input  logic [7:0]          seq_num_i,
  input  logic                success_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [4:0]          missed_count_o,
  output logic [4:0]          entry_count_o,
  output logic signed [15:0]  rssi_avg_out_o,
  output logic                in_cluster_o,
  output logic [16:0]         trust_out_o,
  output logic                head_found_o,
  output logic [31:0]         head_node_id_o,
  output logic [47:0]         head_mac_o
);
  import nte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // config writes are to come only while idle (the block does not enforce this); every transaction is taken at once
  assign cfg_ready_o = 1'b1;

  // state machine: walks the table one entry per read/check pair
  nte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: table ram, blend and trust math, result and output registers
  nte_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .now_ms_i       (now_ms_i),
    .node_id_i      (node_id_i),
    .mac_addr_i     (mac_addr_i),
    .mac_valid_i    (mac_valid_i),
    .rssi_i         (rssi_i),
    .trust_in_i     (trust_in_i),
    .is_head_i      (is_head_i),
    .seq_num_i      (seq_num_i),
    .success_i      (success_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .missed_count_o (missed_count_o),
    .entry_count_o  (entry_count_o),
    .rssi_avg_out_o (rssi_avg_out_o),
    .in_cluster_o   (in_cluster_o),
    .trust_out_o    (trust_out_o),
    .head_found_o   (head_found_o),
    .head_node_id_o (head_node_id_o),
    .head_mac_o     (head_mac_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for neighbor_table_engine_core
// depends on nte_pkg and the rtl under rtl/; keeps its own model of the table
// directed table first, then random beacon, trust, clean and head traffic across several register settings
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nte_pkg::*;

  localparam int DEPTH = TABLE_DEPTH;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 10;
  localparam int RAND_ITEMS = 800;
  localparam int NUM_PHASES = 5;
  localparam int POOL = 20;

  typedef struct {
    op_e         op;
    logic [31:0] now;
    logic [31:0] id;
    logic [47:0] mac;
    logic        mac_ok;
    logic [7:0]  rssi;
    logic [16:0] trust;
    logic        head;
    logic [7:0]  seq;
    logic        succ;
  } beacon_item_t;

  typedef struct {
    status_e     status;
    logic [4:0]  missed;
    logic [4:0]  count;
    logic [15:0] avg;
    logic        in_cl;
    logic [16:0] trust;
    logic        hfound;
    logic [31:0] hid;
    logic [47:0] hmac;
  } table_answer_t;

  typedef struct {
    beacon_item_t it;
    bit           typed;
    status_e      st;
    logic [4:0]   cnt;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [1:0] op_i;
  logic [31:0] now_ms_i, node_id_i;
  logic [47:0] mac_addr_i;
  logic mac_valid_i;
  logic signed [7:0] rssi_i;
  logic [16:0] trust_in_i;
  logic is_head_i;
  logic [7:0] seq_num_i;
  logic success_i;
  logic out_valid_o, out_ready_i;
  logic [2:0] status_o;
  logic [4:0] missed_count_o, entry_count_o;
  logic signed [15:0] rssi_avg_out_o;
  logic in_cluster_o;
  logic [16:0] trust_out_o;
  logic head_found_o;
  logic [31:0] head_node_id_o;
  logic [47:0] head_mac_o;

  neighbor_table_engine_core uut (.*);

  // shadow copy of the neighbor table
  logic [31:0] nb_id[DEPTH];
  logic [47:0] nb_mac[DEPTH];
  logic [7:0]  nb_seq[DEPTH];
  int          nb_avg[DEPTH];
  logic [31:0] nb_seen[DEPTH];
  logic        nb_head[DEPTH];
  logic [31:0] nb_htime[DEPTH];
  logic [16:0] nb_trust[DEPTH];
  int          nb_count;

  // shadow configuration
  int          weight;
  logic [31:0] nb_timeout, hd_timeout;
  int          threshold;

  table_answer_t pending_answers[$];
  int errors = 0, items_sent, answers_seen = 0, cfg_writes;
  int idle_cycles = 0;
  bit stop_stall;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at answer %0d: %s got %0h expected %0h", answers_seen, field, got, want);
    errors++;
  endtask

  function automatic int find_neighbor(logic [31:0] id);
    for (int i = 0; i < nb_count; i++)
      if (nb_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void fill_entry(int e, ref table_answer_t r);
    r.avg = nb_avg[e][15:0];
    r.in_cl = (nb_avg[e] >= threshold * 256);
    r.trust = nb_trust[e];
  endfunction

  // table behavior: updates the shadow state and returns the answer
  function automatic table_answer_t predict_table_op(beacon_item_t it);
    table_answer_t r;
    int k, w, e, rs;
    longint sum, wt;
    logic [7:0] gap;
    logic [16:0] tr;
    r = '{status: ST_UPDATED, default: '0};
    rs = $signed(it.rssi);
    tr = (it.trust > TRUST_ONE) ? TRUST_ONE : it.trust;
    case (it.op)
      OP_BEACON: begin
        k = find_neighbor(it.id);
        if (k >= 0) begin
          gap = it.seq - nb_seq[k];
          r.missed = (gap > 1 && gap - 1 <= 20) ? 5'(gap - 1) : 5'd0;
          nb_seq[k] = it.seq;
          if (it.mac_ok) nb_mac[k] = it.mac;
          if (nb_avg[k] == 0) begin
            nb_avg[k] = rs * 256;
          end else begin
            wt = (weight > 256) ? 256 : weight;
            sum = wt * (rs * 256) + (256 - wt) * nb_avg[k] + 128;
            nb_avg[k] = int'(sum >>> 8);
          end
          nb_trust[k] = tr;
          nb_seen[k] = it.now;
          nb_head[k] = it.head;
          if (it.head) nb_htime[k] = it.now;
          r.status = ST_UPDATED;
          fill_entry(k, r);
        end else if (nb_count < DEPTH) begin
          e = nb_count;
          nb_id[e] = it.id;
          nb_mac[e] = it.mac_ok ? it.mac : 48'd0;
          nb_avg[e] = rs * 256;
          nb_trust[e] = tr;
          nb_seen[e] = it.now;
          nb_head[e] = it.head;
          nb_htime[e] = it.head ? it.now : 32'd0;
          nb_seq[e] = it.seq;
          nb_count++;
          r.status = ST_ADDED;
          fill_entry(e, r);
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_TRUST: begin
        k = find_neighbor(it.id);
        if (k >= 0) begin
          nb_trust[k] = 17'((9 * int'(nb_trust[k]) + (it.succ ? 65536 : 0) + 5) / 10);
          r.status = ST_UPDATED;
          fill_entry(k, r);
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_CLEAN: begin
        w = 0;
        for (int i = 0; i < nb_count; i++) begin
          if (32'(it.now - nb_seen[i]) < nb_timeout) begin
            nb_id[w] = nb_id[i];
            nb_mac[w] = nb_mac[i];
            nb_seq[w] = nb_seq[i];
            nb_avg[w] = nb_avg[i];
            nb_seen[w] = nb_seen[i];
            nb_head[w] = nb_head[i];
            nb_htime[w] = nb_htime[i];
            nb_trust[w] = nb_trust[i];
            w++;
          end
        end
        nb_count = w;
        r.status = ST_CLEANED;
      end
      default: begin
        r.status = ST_HEAD;
        for (int i = 0; i < nb_count; i++) begin
          if (nb_head[i] && 32'(it.now - nb_htime[i]) < hd_timeout) begin
            r.hfound = 1'b1;
            r.hid = nb_id[i];
            r.hmac = nb_mac[i];
            break;
          end
        end
      end
    endcase
    r.count = 5'(nb_count);
    return r;
  endfunction

  // one input transaction; a zero gap keeps valid high back to back
  task automatic send_item(beacon_item_t it, bit typed, status_e st, logic [4:0] cnt);
    table_answer_t r;
    int gap, pick;
    pick = $urandom_range(0, 19);
    gap = (pick < 12) ? 0 : (pick < 18) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= it.op;
    now_ms_i <= it.now;
    node_id_i <= it.id;
    mac_addr_i <= it.mac;
    mac_valid_i <= it.mac_ok;
    rssi_i <= it.rssi;
    trust_in_i <= it.trust;
    is_head_i <= it.head;
    seq_num_i <= it.seq;
    success_i <= it.succ;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = predict_table_op(it);
    // typed rows carry a plain answer with every data field zero
    if (typed) r = '{status: st, count: cnt, default: '0};
    pending_answers.push_back(r);
    items_sent++;
  endtask

  // drain everything in flight and let the scan settle before touching registers
  task automatic wait_idle();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_WEIGHT:   weight = int'(data[8:0]);
      REG_NB_TMO:   nb_timeout = data;
      REG_HEAD_TMO: hd_timeout = data;
      default:      threshold = int'($signed(data[7:0]));
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  function automatic beacon_item_t mk(op_e op, logic [31:0] now, logic [31:0] id,
                                      logic [47:0] mac, logic mac_ok, logic [7:0] rssi,
                                      logic [16:0] trust, logic head, logic [7:0] seq,
                                      logic succ);
    beacon_item_t it;
    it = '{op: op, now: now, id: id, mac: mac, mac_ok: mac_ok, rssi: rssi,
           trust: trust, head: head, seq: seq, succ: succ};
    return it;
  endfunction

  // output side: random backpressure and in-order compare
  initial begin
    int pick, len;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      pick = $urandom_range(0, 19);
      if (stop_stall || pick < 10) begin
        out_ready_i <= 1'b1;
        len = $urandom_range(1, 40);
      end else begin
        out_ready_i <= 1'b0;
        len = (pick < 18) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      end
      repeat (len) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    table_answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("answer with nothing pending", 1, 0);
      end else begin
        want = pending_answers.pop_front();
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (missed_count_o != want.missed)
          report_mismatch("missed_count", missed_count_o, want.missed);
        if (entry_count_o != want.count) report_mismatch("entry_count", entry_count_o, want.count);
        if (rssi_avg_out_o != want.avg) report_mismatch("rssi_avg", rssi_avg_out_o, want.avg);
        if (in_cluster_o != want.in_cl) report_mismatch("in_cluster", in_cluster_o, want.in_cl);
        if (trust_out_o != want.trust) report_mismatch("trust", trust_out_o, want.trust);
        if (head_found_o != want.hfound) report_mismatch("head_found", head_found_o, want.hfound);
        if (head_node_id_o != want.hid) report_mismatch("head_id", head_node_id_o, want.hid);
        if (head_mac_o != want.hmac) report_mismatch("head_mac", head_mac_o, want.hmac);
      end
      answers_seen++;
    end
  end

  // watchdog on cycles where no channel moves a transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // main stimulus
  initial begin
    dir_row_t rows[$];
    beacon_item_t it;
    logic [31:0] pool_id[POOL];
    logic [7:0] pool_seq[POOL];
    logic [31:0] t;
    logic [31:0] ph_nb[NUM_PHASES];
    logic [31:0] ph_hd[NUM_PHASES];
    int ph_w[NUM_PHASES];
    int ph_th[NUM_PHASES];
    int p, pick, n;

    ph_nb = '{32'd30000, 32'hFFFF_FFFF, 32'd0, 32'd20000, 32'd30000};
    ph_hd = '{32'd10000, 32'hFFFF_FFFF, 32'd0, 32'd5000, 32'd10000};
    ph_w = '{77, 0, 256, 511, 0};
    ph_th = '{-70, -128, 127, 0, -70};
    items_sent = 0; cfg_writes = 0;
    stop_stall = 0;
    nb_count = 0;
    weight = 77; nb_timeout = 30000; hd_timeout = 10000; threshold = -70;
    cfg_valid_i = 0; cfg_index_i = REG_WEIGHT; cfg_data_i = '0;
    in_valid_i = 0; op_i = OP_BEACON; now_ms_i = '0; node_id_i = '0; mac_addr_i = '0;
    mac_valid_i = 0; rssi_i = '0; trust_in_i = '0; is_head_i = 0; seq_num_i = '0;
    success_i = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, reset values of the registers
    rows.push_back('{mk(OP_HEAD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_HEAD, 0});
    rows.push_back('{mk(OP_TRUST, 10, 5, 0, 0, 0, 0, 0, 0, 1), 1, ST_NOT_FOUND, 0});
    rows.push_back('{mk(OP_CLEAN, 20, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_CLEANED, 0});
    // lowest id, lowest rssi, trust above one, mac dropped
    rows.push_back('{mk(OP_BEACON, 100, 0, 48'hFFFF_FFFF_FFFF, 0, 8'h80, 17'h1FFFF, 1, 8'hFF, 0),
                     0, ST_ADDED, 0});
    rows.push_back('{mk(OP_BEACON, 200, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 8'h7F, 0, 0, 0, 0),
                     0, ST_ADDED, 0});
    // sequence wrap, normal gap, gap just over the limit, gap at the limit, repeat
    rows.push_back('{mk(OP_BEACON, 300, 0, 48'h0123_4567_89AB, 1, 8'h00, 65536, 1, 0, 0),
                     0, ST_ADDED, 0});
    rows.push_back('{mk(OP_BEACON, 400, 0, 0, 0, 8'hC0, 30000, 1, 5, 0), 0, ST_ADDED, 0});
    rows.push_back('{mk(OP_BEACON, 500, 0, 0, 0, 8'hB0, 100, 1, 27, 0), 0, ST_ADDED, 0});
    rows.push_back('{mk(OP_BEACON, 600, 0, 0, 0, 8'hB5, 1, 1, 48, 0), 0, ST_ADDED, 0});
    rows.push_back('{mk(OP_BEACON, 700, 0, 0, 0, 8'hA0, 65535, 1, 48, 0), 0, ST_ADDED, 0});
    rows.push_back('{mk(OP_TRUST, 710, 0, 0, 0, 0, 0, 0, 0, 1), 0, ST_ADDED, 0});
    rows.push_back('{mk(OP_TRUST, 720, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_ADDED, 0});
    rows.push_back('{mk(OP_TRUST, 730, 7, 0, 0, 0, 0, 0, 0, 1), 1, ST_NOT_FOUND, 2});
    rows.push_back('{mk(OP_HEAD, 5000, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_ADDED, 0});
    // head age equal to the timeout no longer counts
    rows.push_back('{mk(OP_HEAD, 10700, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_HEAD, 2});
    // zero average is reloaded from the next sample
    rows.push_back('{mk(OP_BEACON, 20000, 9, 48'hA5A5_5A5A_A5A5, 1, 8'h00, 0, 0, 3, 0),
                     0, ST_ADDED, 0});
    rows.push_back('{mk(OP_BEACON, 20100, 9, 0, 0, 8'hCE, 0, 0, 4, 0), 0, ST_ADDED, 0});
    rows.push_back('{mk(OP_CLEAN, 30650, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_ADDED, 0});
    rows.push_back('{mk(OP_CLEAN, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0), 0, ST_ADDED, 0});
    rows.push_back('{mk(OP_HEAD, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_HEAD, 0});
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].st, rows[i].cnt);

    // id pool keeps lookups hitting and lets the table fill up
    foreach (pool_id[i]) begin
      pool_id[i] = $urandom();
      pool_seq[i] = $urandom_range(0, 255);
    end
    pool_id[0] = 32'd0;
    pool_id[1] = 32'hFFFF_FFFF;
    t = 32'd1000;

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(REG_WEIGHT, 32'(ph_w[p]));
      write_reg(REG_NB_TMO, ph_nb[p]);
      write_reg(REG_HEAD_TMO, ph_hd[p]);
      write_reg(REG_THRESH, (p == NUM_PHASES - 1) ? 32'($signed(8'($urandom())))
                                                   : 32'(ph_th[p]));
      if (p == NUM_PHASES - 1) write_reg(REG_WEIGHT, $urandom_range(1, 255));
      // one phase runs across the 32-bit time wrap
      if (p == 3) t = 32'hFFFF_0000;
      stop_stall = (p == 2);
      for (n = 0; n < RAND_ITEMS / NUM_PHASES; n++) begin
        // one hold-off in the middle of a phase until everything has drained
        if (p == 1 && n == 80) begin
          @(posedge clk_i);
          in_valid_i <= 1'b0;
          wait (pending_answers.size() == 0);
        end
        pick = $urandom_range(0, 99);
        t = t + (($urandom_range(0, 49) == 0) ? $urandom_range(20000, 60000)
                                                : $urandom_range(0, 3000));
        it.now = t;
        it.op = (pick < 55) ? OP_BEACON : (pick < 75) ? OP_TRUST :
                (pick < 85) ? OP_CLEAN : OP_HEAD;
        pick = $urandom_range(0, POOL - 1);
        it.id = ($urandom_range(0, 19) == 0) ? $urandom() : pool_id[pick];
        pool_seq[pick] = ($urandom_range(0, 9) < 8) ? pool_seq[pick] + 8'($urandom_range(0, 3))
                                                      : 8'($urandom());
        it.seq = pool_seq[pick];
        it.mac = {16'($urandom()), 32'($urandom())};
        it.mac_ok = $urandom_range(0, 1);
        it.rssi = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 60) - 100);
        it.trust = ($urandom_range(0, 9) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536));
        it.head = ($urandom_range(0, 3) == 0);
        it.succ = $urandom_range(0, 1);
        send_item(it, 0, ST_UPDATED, 0);
      end
    end

    stop_stall = 0;
    wait_idle();
    $display("covered %0d items and %0d register writes over %0d settings",
             items_sent, cfg_writes, NUM_PHASES + 1);
    $display("%0d answers checked, %0d mismatches", answers_seen, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
